### design/assert_macros.svh
// Assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TVGQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define TVGQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TVGQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define TVGQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/tvgq_pkg.sv
`default_nettype none

package tvgq_pkg;

    localparam int DEF_MAX_COLUMNS = 8;
    localparam int DEF_MAX_ROWS    = 8;
    localparam int DEF_FRAC_BITS   = 4;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ERROR_LIMIT,
        REG_DRIFT_LIMIT_SQ,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_GRID_COLUMNS,
        REG_GRID_ROWS,
        REG_CELL_QUOTA
    } cfg_reg_t;

    typedef enum logic [2:0] {
        VERDICT_KEPT,
        VERDICT_LOST,
        VERDICT_NOISY,
        VERDICT_DRIFTED,
        VERDICT_OUTSIDE,
        VERDICT_OVER_QUOTA
    } verdict_t;

    typedef struct packed {
        logic [15:0] error_limit;
        logic [23:0] drift_limit_sq;
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [3:0]  grid_columns;
        logic [3:0]  grid_rows;
        logic [9:0]  cell_quota;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        error_limit:    16'd480,
        drift_limit_sq: 24'd256,
        frame_width:    11'd640,
        frame_height:   11'd360,
        grid_columns:   4'd4,
        grid_rows:      4'd3,
        cell_quota:     10'd59
    };

    // screening result handed to the quota stage
    typedef struct packed {
        logic     valid;
        logic     frame_start;
        logic     survive;
        verdict_t verdict;
    } stage_ctrl_t;

    typedef struct packed {
        logic     valid;
        logic     keep;
        verdict_t verdict;
    } res_t;

endpackage

`default_nettype wire

### design/tvgq_ram.sv
`default_nettype none

module tvgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/tvgq_screen.sv
`default_nettype none

module tvgq_screen
    import tvgq_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    localparam int CELLS  = MAX_COLUMNS * MAX_ROWS,
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               in_valid,
    input  wire logic               frame_start,
    input  wire logic               found_forward,
    input  wire logic               found_backward,
    input  wire logic        [15:0] patch_error,
    input  wire logic        [15:0] prev_x,
    input  wire logic        [15:0] prev_y,
    input  wire logic        [15:0] fwd_x,
    input  wire logic        [15:0] fwd_y,
    input  wire logic        [15:0] back_x,
    input  wire logic        [15:0] back_y,
    input  wire logic        [31:0] track_id,
    input  wire cfg_t               cfg,
    output stage_ctrl_t             cand,
    output logic       [CELL_W-1:0] cand_cell,
    output logic signed [16:0]      cand_hop_x,
    output logic signed [16:0]      cand_hop_y,
    output logic       [31:0]       cand_id
);

    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CY_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int POS_W  = 15;
    localparam int SPAN_W = 11 + FRAC_BITS;
    localparam int GRID_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W  = ((SPAN_W > POS_W) ? SPAN_W : POS_W) + GRID_W;
    localparam int PX_W   = POS_W + COL_W;
    localparam int PY_W   = POS_W + ROW_W;
    localparam int CW_W   = CELL_W + COL_W;

    // grid size and frame span; the user keeps them static while items are in flight, not enforced here
    logic [COL_W-1:0]  cols;
    logic [ROW_W-1:0]  rows;
    logic [SPAN_W-1:0] span_x;
    logic [SPAN_W-1:0] span_y;

    always_comb
    begin
        if (cfg.grid_columns == '0)
            cols = COL_W'(1);
        else if (int'(cfg.grid_columns) > MAX_COLUMNS)
            cols = COL_W'(MAX_COLUMNS);
        else
            cols = COL_W'(cfg.grid_columns);

        if (cfg.grid_rows == '0)
            rows = ROW_W'(1);
        else if (int'(cfg.grid_rows) > MAX_ROWS)
            rows = ROW_W'(MAX_ROWS);
        else
            rows = ROW_W'(cfg.grid_rows);

        span_x = SPAN_W'(cfg.frame_width) << FRAC_BITS;
        span_y = SPAN_W'(cfg.frame_height) << FRAC_BITS;
    end

    // stage 1: input register
    logic        p1_valid_reg;
    logic        p1_fs_reg;
    logic        p1_ff_reg;
    logic        p1_fb_reg;
    logic [15:0] p1_perr_reg;
    logic [15:0] p1_px_reg;
    logic [15:0] p1_py_reg;
    logic [15:0] p1_fx_reg;
    logic [15:0] p1_fy_reg;
    logic [15:0] p1_bx_reg;
    logic [15:0] p1_by_reg;
    logic [31:0] p1_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_fs_reg   <= frame_start;
            p1_ff_reg   <= found_forward;
            p1_fb_reg   <= found_backward;
            p1_perr_reg <= patch_error;
            p1_px_reg   <= prev_x;
            p1_py_reg   <= prev_y;
            p1_fx_reg   <= fwd_x;
            p1_fy_reg   <= fwd_y;
            p1_bx_reg   <= back_x;
            p1_by_reg   <= back_y;
            p1_id_reg   <= track_id;
        end
    end

    // stage 1 logic: lost flag, drift squares, hops, range tests, bin products
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] sq_x_full;
    logic signed [33:0] sq_y_full;
    logic signed [16:0] hop_x;
    logic signed [16:0] hop_y;
    logic               lost;
    logic               noisy;
    logic               outside;
    logic [PX_W-1:0]    prod_x;
    logic [PY_W-1:0]    prod_y;

    always_comb
    begin
        dx = $signed({p1_bx_reg[15], p1_bx_reg}) - $signed({p1_px_reg[15], p1_px_reg});
        dy = $signed({p1_by_reg[15], p1_by_reg}) - $signed({p1_py_reg[15], p1_py_reg});
        sq_x_full = dx * dx;
        sq_y_full = dy * dy;
        hop_x = $signed({p1_fx_reg[15], p1_fx_reg}) - $signed({p1_px_reg[15], p1_px_reg});
        hop_y = $signed({p1_fy_reg[15], p1_fy_reg}) - $signed({p1_py_reg[15], p1_py_reg});
        lost  = !p1_ff_reg || !p1_fb_reg;
        noisy = p1_perr_reg > cfg.error_limit;
        outside = (cfg.frame_width == '0) || (cfg.frame_height == '0)
               || p1_fx_reg[15] || p1_fy_reg[15]
               || (CMP_W'(p1_fx_reg[POS_W-1:0]) >= CMP_W'(span_x))
               || (CMP_W'(p1_fy_reg[POS_W-1:0]) >= CMP_W'(span_y));
        prod_x = PX_W'(p1_fx_reg[POS_W-1:0]) * PX_W'(cols);
        prod_y = PY_W'(p1_fy_reg[POS_W-1:0]) * PY_W'(rows);
    end

    // stage 2 register
    logic               p2_valid_reg;
    logic               p2_fs_reg;
    logic               p2_lost_reg;
    logic               p2_noisy_reg;
    logic               p2_outside_reg;
    logic [32:0]        p2_sq_x_reg;
    logic [32:0]        p2_sq_y_reg;
    logic [PX_W-1:0]    p2_prod_x_reg;
    logic [PY_W-1:0]    p2_prod_y_reg;
    logic signed [16:0] p2_hop_x_reg;
    logic signed [16:0] p2_hop_y_reg;
    logic [31:0]        p2_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p2_fs_reg      <= p1_fs_reg;
            p2_lost_reg    <= lost;
            p2_noisy_reg   <= noisy;
            p2_outside_reg <= outside;
            p2_sq_x_reg    <= sq_x_full[32:0];
            p2_sq_y_reg    <= sq_y_full[32:0];
            p2_prod_x_reg  <= prod_x;
            p2_prod_y_reg  <= prod_y;
            p2_hop_x_reg   <= hop_x;
            p2_hop_y_reg   <= hop_y;
            p2_id_reg      <= p1_id_reg;
        end
    end

    // stage 2 logic: drift compare, verdict, cell index
    logic [33:0]     d2;
    logic            drifted;
    verdict_t        verdict;
    logic [CX_W-1:0] cx;
    logic [CY_W-1:0] cy;
    logic [CW_W-1:0] cell_wide;

    always_comb
    begin
        d2 = {1'b0, p2_sq_x_reg} + {1'b0, p2_sq_y_reg};
        drifted = d2 > 34'(cfg.drift_limit_sq);

        if (p2_lost_reg)
            verdict = VERDICT_LOST;
        else if (p2_noisy_reg)
            verdict = VERDICT_NOISY;
        else if (drifted)
            verdict = VERDICT_DRIFTED;
        else if (p2_outside_reg)
            verdict = VERDICT_OUTSIDE;
        else
            verdict = VERDICT_KEPT;

        // bin thresholds are monotonic: take the highest one reached
        cx = '0;
        for (int k = 1; k < MAX_COLUMNS; k++)
        begin
            if ((k < int'(cols))
                && (CMP_W'(p2_prod_x_reg) >= CMP_W'(k) * CMP_W'(span_x)))
                cx = CX_W'(k);
        end
        cy = '0;
        for (int k = 1; k < MAX_ROWS; k++)
        begin
            if ((k < int'(rows))
                && (CMP_W'(p2_prod_y_reg) >= CMP_W'(k) * CMP_W'(span_y)))
                cy = CY_W'(k);
        end

        cell_wide = CW_W'(cy) * CW_W'(cols) + CW_W'(cx);
    end

    always_comb
    begin
        cand.valid       = p2_valid_reg;
        cand.frame_start = p2_fs_reg;
        cand.survive     = (verdict == VERDICT_KEPT);
        cand.verdict     = verdict;
        cand_cell        = (verdict == VERDICT_KEPT) ? cell_wide[CELL_W-1:0] : '0;
        cand_hop_x       = p2_hop_x_reg;
        cand_hop_y       = p2_hop_y_reg;
        cand_id          = p2_id_reg;
    end

endmodule

`default_nettype wire

### design/tvgq_quota.sv
`default_nettype none
`include "assert_macros.svh"

module tvgq_quota
    import tvgq_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    localparam int CELLS  = MAX_COLUMNS * MAX_ROWS,
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire stage_ctrl_t        cand,
    input  wire logic  [CELL_W-1:0] cand_cell,
    input  wire logic signed [16:0] cand_hop_x,
    input  wire logic signed [16:0] cand_hop_y,
    input  wire logic        [31:0] cand_id,
    input  wire logic         [9:0] cell_quota,
    output res_t                    res,
    output logic     [CELL_W-1:0]   res_cell,
    output logic signed [16:0]      res_hop_x,
    output logic signed [16:0]      res_hop_y,
    output logic        [31:0]      res_id
);

    stage_ctrl_t        p3_ctrl_reg;
    logic [CELL_W-1:0]  p3_cell_reg;
    logic signed [16:0] p3_hop_x_reg;
    logic signed [16:0] p3_hop_y_reg;
    logic [31:0]        p3_id_reg;

    // per-cell valid flags: a cleared flag reads as a zero count
    logic [CELLS-1:0]   cvalid_reg;
    logic [CELLS-1:0]   cvalid_next;

    // bypass of the write made as this item's read was issued
    logic               fwd_vld_reg;
    logic [CELL_W-1:0]  fwd_cell_reg;
    logic [COUNT_W-1:0] fwd_count_reg;

    logic               ram_we;
    logic [COUNT_W-1:0] ram_wdata;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] base;
    verdict_t           verdict;

    tvgq_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CELLS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p3_cell_reg),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (cand_cell),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_ctrl_reg <= '0;
            cvalid_reg  <= '0;
            fwd_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            p3_ctrl_reg <= cand;
            cvalid_reg  <= cvalid_next;
            fwd_vld_reg <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p3_cell_reg   <= cand_cell;
            p3_hop_x_reg  <= cand_hop_x;
            p3_hop_y_reg  <= cand_hop_y;
            p3_id_reg     <= cand_id;
            fwd_cell_reg  <= p3_cell_reg;
            fwd_count_reg <= ram_wdata;
        end
    end

    always_comb
    begin
        if (p3_ctrl_reg.frame_start)
            base = '0;
        else if (fwd_vld_reg && (fwd_cell_reg == p3_cell_reg))
            base = fwd_count_reg;
        else if (cvalid_reg[p3_cell_reg])
            base = ram_rdata;
        else
            base = '0;

        ram_wdata = (base == COUNT_MAX) ? base : base + COUNT_W'(1);
        ram_we    = advance && p3_ctrl_reg.valid && p3_ctrl_reg.survive;

        cvalid_next = cvalid_reg;
        if (p3_ctrl_reg.valid && p3_ctrl_reg.frame_start)
            cvalid_next = '0;
        if (ram_we)
            cvalid_next[p3_cell_reg] = 1'b1;

        if (!p3_ctrl_reg.survive)
            verdict = p3_ctrl_reg.verdict;
        else if (ram_wdata <= COUNT_W'(cell_quota))
            verdict = VERDICT_KEPT;
        else
            verdict = VERDICT_OVER_QUOTA;

        res.valid   = p3_ctrl_reg.valid;
        res.keep    = (verdict == VERDICT_KEPT);
        res.verdict = verdict;
        res_cell    = p3_cell_reg;
        res_hop_x   = p3_hop_x_reg;
        res_hop_y   = p3_hop_y_reg;
        res_id      = p3_id_reg;
    end

    `TVGQ_ASSERT_IMPLY(a_write_nonzero, clk, rst_n, ram_we, ram_wdata != '0)
    `TVGQ_ASSERT_NEXT(a_frame_clear, clk, rst_n, advance && p3_ctrl_reg.valid && p3_ctrl_reg.frame_start, $countones(cvalid_reg) <= 1)
    `TVGQ_ASSERT_IMPLY(a_kept_survivor, clk, rst_n, p3_ctrl_reg.valid && verdict == VERDICT_KEPT, p3_ctrl_reg.survive)
    `TVGQ_ASSERT_IMPLY(a_bypass_cell_valid, clk, rst_n, fwd_vld_reg, cvalid_reg[fwd_cell_reg])

endmodule

`default_nettype wire

### design/track_validate_grid_quota.sv
`default_nettype none

// Point screening with per-cell quotas. Each item is one tracked point; it is
// rejected as lost, noisy, drifted or outside the frame, in that order, and a
// survivor bumps a saturating occupancy counter for its grid cell and is kept
// while that count is within cell_quota. One item is accepted per cycle when
// the output side keeps up. Each result passes through the input register, the
// square/bin-product stage, the drift compare and cell index stage, and the
// counter read-modify-write into the output register. The rate is set
// by the simple dual-port counter memory, which does one read and one write per
// cycle with a bypass of the previous write. The whole pipeline stalls while a
// result sits unaccepted with tready low. Counters clear when an item with
// frame_start reaches the counter stage, through per-cell valid flags; no
// clearing pass is needed after reset. Configuration is taken at any time but
// must only change while no item is in flight.
module track_validate_grid_quota
    import tvgq_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // found_forward, found_backward, patch_error, prev_x, prev_y, fwd_x, fwd_y,
    // back_x, back_y, track_id, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // frame_start
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // keep, verdict, hop_x, hop_y, out_id, cell_number, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ERROR_LIMIT:    cfg_next.error_limit    = cfg_data[15:0];
                REG_DRIFT_LIMIT_SQ: cfg_next.drift_limit_sq = cfg_data[23:0];
                REG_FRAME_WIDTH:    cfg_next.frame_width    = cfg_data[10:0];
                REG_FRAME_HEIGHT:   cfg_next.frame_height   = cfg_data[10:0];
                REG_GRID_COLUMNS:   cfg_next.grid_columns   = cfg_data[3:0];
                REG_GRID_ROWS:      cfg_next.grid_rows      = cfg_data[3:0];
                REG_CELL_QUOTA:     cfg_next.cell_quota     = cfg_data[9:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic               advance;

    stage_ctrl_t        cand;
    logic [CELL_W-1:0]  cand_cell;
    logic signed [16:0] cand_hop_x;
    logic signed [16:0] cand_hop_y;
    logic [31:0]        cand_id;

    res_t               res;
    logic [CELL_W-1:0]  res_cell;
    logic signed [16:0] res_hop_x;
    logic signed [16:0] res_hop_y;
    logic [31:0]        res_id;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    tvgq_screen #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_screen (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (s_axis_tvalid),
        .frame_start    (s_axis_tuser),
        .found_forward  (s_axis_tdata[0]),
        .found_backward (s_axis_tdata[1]),
        .patch_error    (s_axis_tdata[17:2]),
        .prev_x         (s_axis_tdata[33:18]),
        .prev_y         (s_axis_tdata[49:34]),
        .fwd_x          (s_axis_tdata[65:50]),
        .fwd_y          (s_axis_tdata[81:66]),
        .back_x         (s_axis_tdata[97:82]),
        .back_y         (s_axis_tdata[113:98]),
        .track_id       (s_axis_tdata[145:114]),
        .cfg            (cfg_reg),
        .cand           (cand),
        .cand_cell      (cand_cell),
        .cand_hop_x     (cand_hop_x),
        .cand_hop_y     (cand_hop_y),
        .cand_id        (cand_id)
    );

    tvgq_quota #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_quota (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cand       (cand),
        .cand_cell  (cand_cell),
        .cand_hop_x (cand_hop_x),
        .cand_hop_y (cand_hop_y),
        .cand_id    (cand_id),
        .cell_quota (cfg_reg.cell_quota),
        .res        (res),
        .res_cell   (res_cell),
        .res_hop_x  (res_hop_x),
        .res_hop_y  (res_hop_y),
        .res_id     (res_id)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_data_reg <= {4'b0000, 6'(res_cell), res_id, res_hop_y, res_hop_x,
                             res.verdict, res.keep};
        end
    end

endmodule

`default_nettype wire
